// ===== sv/ogbd_pkg.sv =====
// Shared constants, types and helpers for the occupancy grid block downsampler.
package ogbd_pkg;

    localparam int OGBD_OUT_CELLS = 20;
    localparam int BLOCK          = 7;
    localparam int SRC_DIM        = 256;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int OCC_W   = 8;
    localparam int OROW_W  = 5;
    localparam int OCOL_W  = 5;
    localparam int VAL_W   = 7;
    localparam int OFF_W   = 9;
    localparam int SW_W    = 9;
    localparam int THR_W   = 6;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic signed [OFF_W-1:0] ROW_OFF_RST = '0;
    localparam logic signed [OFF_W-1:0] COL_OFF_RST = '0;
    localparam logic [SW_W-1:0]         SRC_W_RST   = 9'd140;
    localparam logic [THR_W-1:0]        THR_RST     = 6'd15;
    localparam logic [VAL_W-1:0]        OCC_VAL_RST = 7'd60;

    // Block index by reciprocal multiply; exact for every 9-bit argument.
    localparam int DIV_SHIFT = 16;
    localparam int BLK_RECIP = (2**DIV_SHIFT + BLOCK - 1) / BLOCK;

    typedef enum logic [2:0] {
        REG_ROW_OFF   = 3'd0,
        REG_COL_OFF   = 3'd1,
        REG_SRC_WIDTH = 3'd2,
        REG_CNT_THR   = 3'd3,
        REG_OCC_VAL   = 3'd4
    } t_reg_idx;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_emit_state;

    typedef struct packed {
        logic load_in;
        logic advance;
        logic start_emit;
        logic next_col;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_hit;
        logic col_last;
    } t_dp_sts;

    function automatic logic [8:0] blk_div(input logic [8:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'(BLK_RECIP);
        return p[DIV_SHIFT +: 9];
    endfunction

endpackage

// ===== sv/ogbd_in_if.sv =====
// Source cell channel: valid/ready handshake with row, column and occupancy.
interface ogbd_in_if import ogbd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        src_row;
    logic [COL_W-1:0]        src_col;
    logic signed [OCC_W-1:0] occupancy;

    modport source (output valid, output src_row, output src_col, output occupancy,
                    input ready);
    modport sink   (input valid, input src_row, input src_col, input occupancy,
                    output ready);
endinterface

// ===== sv/ogbd_out_if.sv =====
// Coarse cell result channel: valid/ready handshake with row, column, value and last.
interface ogbd_out_if import ogbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OROW_W-1:0] out_row;
    logic [OCOL_W-1:0] out_col;
    logic [VAL_W-1:0]  cell_value;
    logic              last;

    modport source (output valid, output out_row, output out_col, output cell_value,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input cell_value,
                    input last, output ready);
endinterface

// ===== sv/ogbd_ctrl.sv =====
// Controller: input stage handshake and coarse row emission sequencing.
module ogbd_ctrl import ogbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_emit_state r_state, n_state;
    logic        r_stg_vld, n_stg_vld;
    logic        hold;
    logic        out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stg_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stg_vld <= n_stg_vld;
        end
    end

    always_comb begin
        // Hold a row end in the stage while the previous row still drains.
        hold             = r_stg_vld && i_sts.emit_hit && (r_state == ST_EMIT);
        o_cmd.advance    = r_stg_vld && !hold;
        o_in_ready       = !r_stg_vld || o_cmd.advance;
        o_cmd.load_in    = i_in_valid && o_in_ready;
        o_cmd.start_emit = o_cmd.advance && i_sts.emit_hit;
        o_out_valid      = (r_state == ST_EMIT);
        out_take         = o_out_valid && i_out_ready;
        o_cmd.next_col   = out_take;

        if (o_cmd.load_in) begin
            n_stg_vld = 1'b1;
        end else if (o_cmd.advance) begin
            n_stg_vld = 1'b0;
        end else begin
            n_stg_vld = r_stg_vld;
        end

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start_emit) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_take && i_sts.col_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/ogbd_dpath.sv =====
// Datapath: configuration registers, input stage, block counters and row snapshot.
module ogbd_dpath import ogbd_pkg::*; #(
    parameter int OUT_CELLS = OGBD_OUT_CELLS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    input  logic [ROW_W-1:0]        i_src_row,
    input  logic [COL_W-1:0]        i_src_col,
    input  logic signed [OCC_W-1:0] i_occupancy,
    output logic [OROW_W-1:0]       o_out_row,
    output logic [OCOL_W-1:0]       o_out_col,
    output logic [VAL_W-1:0]        o_cell_value,
    output logic                    o_last,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts
);

    localparam int SPAN = OUT_CELLS * BLOCK;

    logic signed [OFF_W-1:0] r_row_off;
    logic signed [OFF_W-1:0] r_col_off;
    logic [SW_W-1:0]         r_src_w;
    logic [THR_W-1:0]        r_thr;
    logic [VAL_W-1:0]        r_occ_val;

    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [OCC_W-1:0] r_occ;

    logic [CNT_W-1:0]        r_cnt [OUT_CELLS];
    logic [CNT_W-1:0]        n_cnt [OUT_CELLS];
    logic [OUT_CELLS-1:0]    r_snap;
    logic [OUT_CELLS-1:0]    flags;
    logic [OROW_W-1:0]       r_orow;
    logic [OCOL_W-1:0]       r_ocol;

    logic                    cfg_wr;
    logic signed [9:0]       dr, dc;
    logic                    col_ok, dr_ok, dc_ok, occ_pos, cnt_en;
    logic [8:0]              q_dr, q_dr1, q_dc;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_off <= ROW_OFF_RST;
            r_col_off <= COL_OFF_RST;
            r_src_w   <= SRC_W_RST;
            r_thr     <= THR_RST;
            r_occ_val <= OCC_VAL_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_ROW_OFF:   r_row_off <= pwdata[OFF_W-1:0];
                REG_COL_OFF:   r_col_off <= pwdata[OFF_W-1:0];
                REG_SRC_WIDTH: r_src_w   <= pwdata[SW_W-1:0];
                REG_CNT_THR:   r_thr     <= pwdata[THR_W-1:0];
                REG_OCC_VAL:   r_occ_val <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_ROW_OFF:   prdata = DATA_W'(signed'(r_row_off));
            REG_COL_OFF:   prdata = DATA_W'(signed'(r_col_off));
            REG_SRC_WIDTH: prdata = DATA_W'(r_src_w);
            REG_CNT_THR:   prdata = DATA_W'(r_thr);
            REG_OCC_VAL:   prdata = DATA_W'(r_occ_val);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_row <= i_src_row;
            r_col <= i_src_col;
            r_occ <= i_occupancy;
        end
    end

    always_comb begin
        dr      = signed'({2'b00, r_row}) - 10'(r_row_off);
        dc      = signed'({2'b00, r_col}) - 10'(r_col_off);
        col_ok  = ({1'b0, r_col} < r_src_w) && ({3'b000, r_col} < 11'(SRC_DIM));
        dr_ok   = !dr[9] && (dr < 10'(SPAN));
        dc_ok   = !dc[9] && (dc < 10'(SPAN));
        occ_pos = (r_occ > 0);
        cnt_en  = col_ok && dr_ok && dc_ok && occ_pos;
        q_dr    = blk_div(dr[8:0]);
        q_dr1   = blk_div(dr[8:0] + 9'd1);
        q_dc    = blk_div(dc[8:0]);

        o_sts.emit_hit = col_ok && dr_ok && (({1'b0, r_col} + 9'd1) == r_src_w)
                         && (q_dr1 != q_dr);
        o_sts.col_last = (r_ocol == OCOL_W'(OUT_CELLS - 1));

        for (int k = 0; k < OUT_CELLS; k++) begin
            if (cnt_en && (q_dc == 9'(k)) && (r_cnt[k] != CNT_MAX)) begin
                n_cnt[k] = r_cnt[k] + CNT_W'(1);
            end else begin
                n_cnt[k] = r_cnt[k];
            end
            flags[k] = (n_cnt[k] > r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OUT_CELLS; k++) r_cnt[k] <= '0;
        end else if (i_cmd.advance) begin
            // Clear the counters once the row is captured.
            for (int k = 0; k < OUT_CELLS; k++) begin
                r_cnt[k] <= i_cmd.start_emit ? '0 : n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_snap <= flags;
            r_orow <= q_dr[OROW_W-1:0];
            r_ocol <= '0;
        end else if (i_cmd.next_col) begin
            r_snap <= r_snap >> 1;
            r_ocol <= r_ocol + OCOL_W'(1);
        end
    end

    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_cell_value = r_snap[0] ? r_occ_val : '0;
    assign o_last       = o_sts.col_last;

endmodule

// ===== sv/occupancy_grid_block_downsampler_top.sv =====
// Occupancy grid block downsampler top level.
// Throughput: one source cell per cycle; input stalls only when a block-row end
// reaches the stage register while the previous coarse row is still draining.
// Flow: a row-end cell passes through the stage register, then loads the row snapshot;
// a coarse row is OUT_CELLS results, one per cycle while the sink is ready.
// Reset: synchronous, active low; restores register defaults, clears counters.
module occupancy_grid_block_downsampler_top import ogbd_pkg::*; #(
    parameter int OUT_CELLS = OGBD_OUT_CELLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ogbd_in_if.sink           i_in,
    ogbd_out_if.source        o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;

    ogbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ogbd_dpath #(
        .OUT_CELLS (OUT_CELLS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .i_src_row    (i_in.src_row),
        .i_src_col    (i_in.src_col),
        .i_occupancy  (i_in.occupancy),
        .o_out_row    (o_out.out_row),
        .o_out_col    (o_out.out_col),
        .o_cell_value (o_out.cell_value),
        .o_last       (o_out.last),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule
